### rtl/chacha20_keystream_xor_defines.svh
// ----------------------------------------------------------------------------
// chacha20 keystream xor assertion macros
// clocked on aclk and gated by the active-low reset of the including module
// ----------------------------------------------------------------------------
`ifndef CHACHA20_KEYSTREAM_XOR_DEFINES_SVH
`define CHACHA20_KEYSTREAM_XOR_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define CC20_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// expression must never be true
`define CC20_NEVER(lbl, expr, msg) `CC20_ASSERT(lbl, !(expr), msg)

`else

`define CC20_ASSERT(lbl, prop, msg)
`define CC20_NEVER(lbl, expr, msg)

`endif

`endif

### rtl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// shared constants, types and the half quarter-round function
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 32;
    localparam int NUM_WORDS     = 16;
    localparam int BLOCK_BYTES   = 64;
    localparam int BLOCK_W       = BLOCK_BYTES * BYTE_W;
    localparam int POS_W         = $clog2(BLOCK_BYTES);
    localparam int DOUBLE_ROUNDS = 10;
    localparam int NUM_STEPS     = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W        = $clog2(NUM_STEPS);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int CNT_W         = 64;
    // queue depth stays a power of two so the pointers wrap on their own
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY01,
        REG_KEY23,
        REG_KEY45,
        REG_KEY67,
        REG_NONCE01,
        REG_NONCE2,
        REG_START_CTR,
        REG_RESEED
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN,
        CORE_FIN,
        CORE_DONE
    } core_state_t;

    // one queued item; first marks byte 0 of a new keystream block
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              first;
    } q_item_t;

    // finished keystream block, byte k at bits [8k+7:8k]
    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] bytes;
    } ks_blk_t;

    // key material, word 0 in the low bits
    typedef struct packed {
        logic [8*WORD_W-1:0] key;
        logic [3*WORD_W-1:0] nonce;
    } cc20_key_t;

    // half of a quarter round: {d, c, b, a}
    function automatic logic [4*WORD_W-1:0] qr_half(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d,
        input logic              second
    );
        logic [WORD_W-1:0] a1;
        logic [WORD_W-1:0] dx;
        logic [WORD_W-1:0] d1;
        logic [WORD_W-1:0] c1;
        logic [WORD_W-1:0] bx;
        logic [WORD_W-1:0] b1;
        a1 = a + b;
        dx = d ^ a1;
        d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
        c1 = c + d1;
        bx = b ^ c1;
        b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
        return {d1, c1, b1, a1};
    endfunction

endpackage

### rtl/cc20_front.sv
// ----------------------------------------------------------------------------
// cc20_front
// accepts input items, tags block boundaries and queues them for the back end
// ----------------------------------------------------------------------------
`include "chacha20_keystream_xor_defines.svh"

module cc20_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          restart,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cc20_pkg::BYTE_W-1:0]   s_tdata,   // data_in[7:0]
    input  logic                          s_tlast,
    output cc20_pkg::q_item_t             q_item,
    output logic                          q_valid,
    input  logic                          q_pop
);

    cc20_pkg::q_item_t                mem_reg [cc20_pkg::QDEPTH];
    logic [cc20_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [cc20_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [cc20_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic [cc20_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                             push;
    cc20_pkg::q_item_t                in_item;

    assign s_tready = (cnt_reg != cc20_pkg::QCNT_W'(cc20_pkg::QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        in_item.data  = s_tdata;
        in_item.last  = s_tlast;
        in_item.first = (pos_reg == '0);
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
            pos_next    = pos_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
        // stream restarts at byte 0 of a fresh block
        if (restart) begin
            pos_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            pos_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `CC20_ASSERT(a_q_bound, cnt_reg <= cc20_pkg::QCNT_W'(cc20_pkg::QDEPTH), "queue overfilled")

endmodule

### rtl/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// iterative chacha20 block engine, four half quarter-rounds per cycle
// ----------------------------------------------------------------------------
`include "chacha20_keystream_xor_defines.svh"

module cc20_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          abort,
    input  logic [cc20_pkg::WORD_W-1:0]   ctr_load,
    input  cc20_pkg::cc20_key_t           key,
    input  logic                          take,
    output cc20_pkg::ks_blk_t             blk
);

    localparam int W = cc20_pkg::WORD_W;
    localparam int N = cc20_pkg::NUM_WORDS;

    cc20_pkg::core_state_t                state_reg, state_next;
    logic [cc20_pkg::STEP_W-1:0]          step_reg, step_next;
    logic [W-1:0]                         ctr_reg, ctr_next;
    logic [N-1:0][W-1:0]                  x_reg, x_next;
    logic [N-1:0][W-1:0]                  init;
    logic [N-1:0][W-1:0]                  x_col;
    logic [N-1:0][W-1:0]                  x_diag;
    logic                                 col;
    logic                                 second;

    always_comb begin
        init[0] = cc20_pkg::SIGMA0;
        init[1] = cc20_pkg::SIGMA1;
        init[2] = cc20_pkg::SIGMA2;
        init[3] = cc20_pkg::SIGMA3;
        for (int i = 0; i < 8; i++) begin
            init[4+i] = key.key[i*W +: W];
        end
        init[12] = ctr_reg;
        for (int i = 0; i < 3; i++) begin
            init[13+i] = key.nonce[i*W +: W];
        end
    end

    // step bit 0 picks the half, bit 1 picks column or diagonal round
    assign second = step_reg[0];
    assign col    = !step_reg[1];

    always_comb begin
        x_col  = x_reg;
        x_diag = x_reg;
        for (int q = 0; q < 4; q++) begin
            {x_col[12+q], x_col[8+q], x_col[4+q], x_col[q]} =
                cc20_pkg::qr_half(x_reg[q], x_reg[4+q], x_reg[8+q], x_reg[12+q], second);
            {x_diag[12+((q+3)&3)], x_diag[8+((q+2)&3)], x_diag[4+((q+1)&3)], x_diag[q]} =
                cc20_pkg::qr_half(x_reg[q], x_reg[4+((q+1)&3)], x_reg[8+((q+2)&3)],
                                  x_reg[12+((q+3)&3)], second);
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        ctr_next   = ctr_reg;
        x_next     = x_reg;
        unique case (state_reg)
            cc20_pkg::CORE_IDLE: begin
                x_next     = init;
                step_next  = '0;
                state_next = cc20_pkg::CORE_RUN;
            end
            cc20_pkg::CORE_RUN: begin
                x_next    = col ? x_col : x_diag;
                step_next = step_reg + 1'b1;
                if (step_reg == cc20_pkg::STEP_W'(cc20_pkg::NUM_STEPS - 1)) begin
                    state_next = cc20_pkg::CORE_FIN;
                end
            end
            cc20_pkg::CORE_FIN: begin
                for (int i = 0; i < N; i++) begin
                    x_next[i] = x_reg[i] + init[i];
                end
                state_next = cc20_pkg::CORE_DONE;
            end
            cc20_pkg::CORE_DONE: begin
                if (take) begin
                    ctr_next   = ctr_reg + 1'b1;
                    state_next = cc20_pkg::CORE_IDLE;
                end
            end
            default: begin
                state_next = cc20_pkg::CORE_IDLE;
            end
        endcase
        if (abort) begin
            ctr_next   = ctr_load;
            state_next = cc20_pkg::CORE_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cc20_pkg::CORE_IDLE;
            step_reg  <= '0;
            ctr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ctr_reg   <= ctr_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
    end

    assign blk.valid = (state_reg == cc20_pkg::CORE_DONE);
    assign blk.bytes = x_reg;

    `CC20_ASSERT(a_done_holds, state_reg == cc20_pkg::CORE_DONE && !take && !abort |=> state_reg == cc20_pkg::CORE_DONE, "finished block dropped without take")
    `CC20_ASSERT(a_step_range, state_reg == cc20_pkg::CORE_RUN |-> step_reg < cc20_pkg::STEP_W'(cc20_pkg::NUM_STEPS), "round step out of range")

endmodule

### rtl/cc20_back.sv
// ----------------------------------------------------------------------------
// cc20_back
// combines queued bytes with the keystream, counts blocks, drives the output
// ----------------------------------------------------------------------------
`include "chacha20_keystream_xor_defines.svh"

module cc20_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          restart,
    input  logic [cc20_pkg::CNT_W-1:0]    reseed_interval,
    input  cc20_pkg::q_item_t             q_item,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  cc20_pkg::ks_blk_t             blk,
    output logic                          take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cc20_pkg::BYTE_W-1:0]   m_tdata,   // data_out[7:0]
    output logic                          m_tlast,
    output logic                          m_tuser    // need_reseed
);

    localparam int B  = cc20_pkg::BYTE_W;
    localparam int SW = cc20_pkg::BLOCK_W - B;

    logic [SW-1:0]                    ks_sr_reg, ks_sr_next;
    logic [cc20_pkg::CNT_W-1:0]       made_reg, made_next;
    logic [cc20_pkg::CNT_W-1:0]       made_inc;
    logic                             m_valid_reg;
    logic [B-1:0]                     data_reg;
    logic                             last_reg;
    logic                             reseed_reg;
    logic [B-1:0]                     ks_byte;
    logic                             out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = q_valid && out_free && (!q_item.first || blk.valid);
    assign take     = q_pop && q_item.first;

    // first byte of a block comes straight from the engine, the rest shift out
    assign ks_byte    = q_item.first ? blk.bytes[B-1:0] : ks_sr_reg[B-1:0];
    assign ks_sr_next = q_item.first ? blk.bytes[cc20_pkg::BLOCK_W-1:B]
                                     : {{B{1'b0}}, ks_sr_reg[SW-1:B]};

    assign made_inc = (made_reg == '1) ? made_reg : made_reg + 1'b1;

    always_comb begin
        made_next = made_reg;
        if (take) begin
            made_next = made_inc;
        end
        if (restart) begin
            made_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            made_reg    <= '0;
        end else begin
            made_reg <= made_next;
            if (q_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ks_sr_reg  <= ks_sr_next;
            data_reg   <= q_item.data ^ ks_byte;
            last_reg   <= q_item.last;
            reseed_reg <= (made_next >= reseed_interval);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = reseed_reg;

    `CC20_ASSERT(a_pop_fills_out, q_pop |=> m_valid_reg, "popped item not presented")
    `CC20_ASSERT(a_restart_count, restart |=> made_reg == '0, "block count kept across restart")

endmodule

### rtl/chacha20_keystream_xor.sv
// ----------------------------------------------------------------------------
// chacha20_keystream_xor
// chacha20 stream cipher, one data byte per item
// ----------------------------------------------------------------------------
// Bytes enter on the s_ channel and leave on the m_ channel XORed with the
// next keystream byte; tlast rides along and tuser carries need_reseed.
// Key, nonce, start counter and reseed interval are written on the cfg_
// channel (always ready); the user must write them only while the stream
// is idle, which the block does not enforce. Any write restarts the stream
// at start_counter and clears the produced-block count. Each byte is queued
// and then registered at the output, and while m_tready is high the block
// sustains one item per cycle: the engine computes the next block (load, 40
// half-round steps, feed-forward) while the current 64 bytes drain, so only
// the first byte after reset or a configuration write waits for the first
// block. Reset clears the registers, the block counter and the queue; the
// engine starts the first block at once. When m_tready is low the output
// register holds its item, the two-entry queue fills and s_tready drops.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cc20_pkg::BYTE_W-1:0]       s_tdata,   // data_in[7:0]
    input  logic                              s_tlast,   // last_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cc20_pkg::BYTE_W-1:0]       m_tdata,   // data_out[7:0]
    output logic                              m_tlast,   // last_out
    output logic                              m_tuser,   // need_reseed
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int W = cc20_pkg::WORD_W;

    logic [2*W-1:0]                   key01_reg, key23_reg, key45_reg, key67_reg;
    logic [2*W-1:0]                   nonce01_reg;
    logic [W-1:0]                     nonce2_reg;
    logic [W-1:0]                     start_ctr_reg;
    logic [cc20_pkg::CNT_W-1:0]       reseed_reg;
    logic                             cfg_we;
    cc20_pkg::cfg_reg_t               cfg_sel;
    logic [W-1:0]                     ctr_load;
    cc20_pkg::cc20_key_t              key;
    cc20_pkg::q_item_t                q_item;
    logic                             q_valid;
    logic                             q_pop;
    cc20_pkg::ks_blk_t                blk;
    logic                             take;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_sel   = cc20_pkg::cfg_reg_t'(cfg_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key01_reg     <= '0;
            key23_reg     <= '0;
            key45_reg     <= '0;
            key67_reg     <= '0;
            nonce01_reg   <= '0;
            nonce2_reg    <= '0;
            start_ctr_reg <= '0;
            reseed_reg    <= '0;
        end else if (cfg_we) begin
            if (cfg_sel == cc20_pkg::REG_KEY01)     key01_reg     <= cfg_data;
            if (cfg_sel == cc20_pkg::REG_KEY23)     key23_reg     <= cfg_data;
            if (cfg_sel == cc20_pkg::REG_KEY45)     key45_reg     <= cfg_data;
            if (cfg_sel == cc20_pkg::REG_KEY67)     key67_reg     <= cfg_data;
            if (cfg_sel == cc20_pkg::REG_NONCE01)   nonce01_reg   <= cfg_data;
            if (cfg_sel == cc20_pkg::REG_NONCE2)    nonce2_reg    <= cfg_data[W-1:0];
            if (cfg_sel == cc20_pkg::REG_START_CTR) start_ctr_reg <= cfg_data[W-1:0];
            if (cfg_sel == cc20_pkg::REG_RESEED)    reseed_reg    <= cfg_data;
        end
    end

    // engine reloads the start counter, even one being written this cycle
    assign ctr_load = (cfg_we && cfg_sel == cc20_pkg::REG_START_CTR) ? cfg_data[W-1:0]
                                                                    : start_ctr_reg;

    assign key.key   = {key67_reg, key45_reg, key23_reg, key01_reg};
    assign key.nonce = {nonce2_reg, nonce01_reg};

    cc20_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (cfg_we),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    cc20_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .abort    (cfg_we),
        .ctr_load (ctr_load),
        .key      (key),
        .take     (take),
        .blk      (blk)
    );

    cc20_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .restart         (cfg_we),
        .reseed_interval (reseed_reg),
        .q_item          (q_item),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .blk             (blk),
        .take            (take),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser)
    );

endmodule
